// ===== hw/rtl/ttrc_pkg.sv =====
// ttrc_pkg: shared types and constants for the three-term recurrence checksum
// used by ttrc_term and three_term_recurrence_checksum; no dependencies
`default_nettype none

package ttrc_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] term_t;

  // first byte of a message: newer term is byte plus this offset
  localparam term_t FIRST_OFFSET = 16'd7;
  // per-position coefficients a = 17*i, b = 31*i, both mod 256
  localparam logic [4:0] A_MULT = 5'd17;
  localparam logic [4:0] B_MULT = 5'd31;
  // fold modulus, 2^16 - 1
  localparam term_t MOD_FOLD = 16'hFFFF;
  // reset value of both terms
  localparam term_t TERM_ONE = 16'd1;

endpackage : ttrc_pkg

`default_nettype wire

// ===== hw/rtl/three_term_recurrence_checksum.sv =====
// three_term_recurrence_checksum: top level with input register, recurrence
// state and result register; uses ttrc_pkg and ttrc_term
//
// Usage:
//   Input channel in_valid/in_ready carries one message byte per item in
//   byte_value, with last_byte set on the final byte of a message.
//   Output channel out_valid/out_ready carries one checksum item per
//   message, produced when the last byte is processed.
//   A byte accepted into the input register is folded into the recurrence
//   when it leaves that register; for a last byte the checksum is loaded at
//   that same edge and out_valid is registered with it. A last byte leaves
//   the input register only when the result register is free.
//   Throughput: one byte per cycle while no last byte is held; the term
//   update is a 16x9 and a 16x8 multiply, subtract and mod 65535 fold per cycle.
//   Reset (rst, synchronous): both registers empty, byte index 0, both
//   terms 1, next byte starts a new message.
//   Receiver stall: non-last bytes keep flowing while a checksum waits;
//   a last byte is held in the input register until the result register
//   is free, and in_ready drops only while that byte is held.
`default_nettype none

module three_term_recurrence_checksum (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire ttrc_pkg::byte_t byte_value,
  input  wire                  last_byte,
  output logic                 out_valid,
  input  wire                  out_ready,
  output ttrc_pkg::term_t      checksum
);
  import ttrc_pkg::*;

  // input register
  logic  in_full;
  byte_t in_byte;
  logic  in_last;

  // recurrence state
  byte_t byte_index;
  term_t older_term;
  term_t newer_term;
  logic  started;

  term_t term;
  term_t newer_next;
  logic  advance;

  ttrc_term u_term (
    .byte_value (in_byte),
    .pos        (byte_index),
    .newer      (newer_term),
    .older      (older_term),
    .term       (term)
  );

  // a last byte needs a free result register, other bytes always move on
  assign advance  = in_full && (!in_last || !out_valid || out_ready);
  assign in_ready = !in_full || advance;

  assign newer_next = started ? term : (16'(in_byte) + FIRST_OFFSET);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte <= byte_value;
      in_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= 8'd0;
      older_term <= TERM_ONE;
      newer_term <= TERM_ONE;
      started    <= 1'b0;
    end else if (advance) begin
      if (in_last) begin
        byte_index <= 8'd0;
        older_term <= TERM_ONE;
        newer_term <= TERM_ONE;
        started    <= 1'b0;
      end else begin
        byte_index <= byte_index + 8'd1;
        older_term <= started ? newer_term : TERM_ONE;
        newer_term <= newer_next;
        started    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      checksum <= newer_next;
    end
  end

endmodule : three_term_recurrence_checksum

`default_nettype wire

// ===== hw/rtl/ttrc_term.sv =====
// ttrc_term: next recurrence term from one byte, its position and the two
// previous terms; combinational, uses ttrc_pkg
`default_nettype none

module ttrc_term (
  input  wire ttrc_pkg::byte_t byte_value,
  input  wire ttrc_pkg::byte_t pos,
  input  wire ttrc_pkg::term_t newer,
  input  wire ttrc_pkg::term_t older,
  output ttrc_pkg::term_t      term
);
  import ttrc_pkg::*;

  logic [12:0] a_prod;
  logic [12:0] b_prod;
  byte_t       a;
  byte_t       b;
  logic [8:0]  mult_in;
  logic [24:0] plus;
  logic [24:0] minus;
  logic        plus_ge;
  logic [24:0] diff;
  logic [16:0] fold_sum;
  term_t       red;

  assign a_prod = 13'(pos) * 13'(A_MULT);
  assign b_prod = 13'(pos) * 13'(B_MULT);
  assign a      = a_prod[7:0];
  assign b      = b_prod[7:0];

  assign mult_in = {1'b0, byte_value} + {1'b0, a};
  assign plus    = 25'(mult_in) * 25'(newer);
  assign minus   = 25'(b) * 25'(older);

  assign plus_ge = (plus >= minus);
  assign diff    = plus_ge ? (plus - minus) : (minus - plus);

  // 2^16 is 1 mod 65535, so add the high bits onto the low half
  assign fold_sum = {1'b0, diff[15:0]} + 17'(diff[24:16]);

  always_comb begin
    if (fold_sum >= {1'b0, MOD_FOLD}) begin
      red = 16'(fold_sum - {1'b0, MOD_FOLD});
    end else begin
      red = fold_sum[15:0];
    end
  end

  // negative difference gives (1 - |d|) mod 65535
  always_comb begin
    if (plus_ge) begin
      term = red;
    end else if (red == 16'd0) begin
      term = TERM_ONE;
    end else if (red == TERM_ONE) begin
      term = 16'd0;
    end else begin
      term = 16'(17'h10000 - {1'b0, red});
    end
  end

endmodule : ttrc_term

`default_nettype wire

// ===== tb/sv/tb_three_term_recurrence_checksum.sv =====
// tb_three_term_recurrence_checksum: self-checking bench for the three-term
// recurrence checksum; predicts each message checksum and compares results
// depends on ttrc_pkg and three_term_recurrence_checksum
`timescale 1ns / 1ps

module tb_three_term_recurrence_checksum;
  import ttrc_pkg::*;

  localparam int unsigned FOLD_MOD   = 65535;
  localparam int unsigned START_ADD  = 7;
  localparam int unsigned COEF_A     = 17;
  localparam int unsigned COEF_B     = 31;
  localparam int unsigned RAND_BYTES = 1200;
  localparam int unsigned DRAIN_CYC  = 10;

  typedef struct packed {
    byte_t value;
    logic  is_last;
  } msg_byte_t;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  byte_t byte_value;
  logic  last_byte;
  logic  out_valid;
  logic  out_ready;
  term_t checksum;

  msg_byte_t   pending_bytes[$];
  term_t       expected_sums[$];
  logic        in_taken;
  int unsigned accepted_bytes;
  int unsigned queued_bytes;
  int unsigned fail_count;

  // predicted recurrence state
  byte_t msg_pos;
  term_t prev_term;
  term_t cur_term;
  logic  msg_open;

  three_term_recurrence_checksum dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .checksum   (checksum)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic term_t recurrence_step(byte_t value, byte_t pos, term_t older,
                                            term_t newer);
    int unsigned a;
    int unsigned b;
    int unsigned plus;
    int unsigned minus;
    int unsigned neg;
    a = (int'(pos) * COEF_A) % 256;
    b = (int'(pos) * COEF_B) % 256;
    plus  = (int'(value) + a) * int'(newer);
    minus = b * int'(older);
    if (plus >= minus) begin
      return term_t'((plus - minus) % FOLD_MOD);
    end
    // negative difference folds as difference plus one
    neg = (minus - plus) % FOLD_MOD;
    return term_t'((1 + FOLD_MOD - neg) % FOLD_MOD);
  endfunction

  task automatic reset_checksum_state();
    msg_pos   = '0;
    prev_term = 16'd1;
    cur_term  = 16'd1;
    msg_open  = 1'b0;
  endtask

  task automatic absorb_byte(byte_t value, logic is_last);
    term_t t;
    if (!msg_open) begin
      prev_term = 16'd1;
      cur_term  = term_t'(int'(value) + START_ADD);
      msg_open  = 1'b1;
    end else begin
      t = recurrence_step(value, msg_pos, prev_term, cur_term);
      prev_term = cur_term;
      cur_term  = t;
    end
    msg_pos = msg_pos + 8'd1;
    if (is_last) begin
      expected_sums.push_back(cur_term);
      reset_checksum_state();
    end
  endtask

  // idle percentages by phase: sender first light, then heavy, then none
  function automatic int unsigned sender_idle_pct();
    if (accepted_bytes < 400) return 20;
    if (accepted_bytes < 800) return 45;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    if (accepted_bytes < 400) return 45;
    if (accepted_bytes < 800) return 20;
    return 0;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          byte_value <= pending_bytes[0].value;
          last_byte  <= pending_bytes[0].is_last;
          in_valid   <= 1'b1;
          void'(pending_bytes.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        absorb_byte(byte_value, last_byte);
        accepted_bytes <= accepted_bytes + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          $error("checksum: expected none, actual %0d", checksum);
          fail_count <= fail_count + 1;
        end else begin
          if (checksum !== expected_sums[0]) begin
            $error("checksum: expected %0d, actual %0d", expected_sums[0], checksum);
            fail_count <= fail_count + 1;
          end
          void'(expected_sums.pop_front());
        end
      end
    end
  end

  task automatic queue_byte(byte_t value, logic is_last);
    msg_byte_t item;
    item.value   = value;
    item.is_last = is_last;
    pending_bytes.push_back(item);
    queued_bytes++;
  endtask

  task automatic queue_message(int unsigned len);
    byte_t value;
    int unsigned pick;
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) value = 8'h00;
      else if (pick < 24) value = 8'hFF;
      else value = byte_t'($urandom_range(0, 255));
      queue_byte(value, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || expected_sums.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int unsigned len;
    logic long_done;
    logic paused;
    rst            = 1'b1;
    in_valid       = 1'b0;
    byte_value     = '0;
    last_byte      = 1'b0;
    out_ready      = 1'b0;
    in_taken       = 1'b0;
    accepted_bytes = 0;
    queued_bytes   = 0;
    fail_count     = 0;
    long_done      = 1'b0;
    paused         = 1'b0;
    reset_checksum_state();
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // one-byte messages at both byte extremes
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    // all-ones message drives large terms
    for (int i = 0; i < 4; i++) queue_byte(8'hFF, i == 3);
    // all-zero message
    for (int i = 0; i < 5; i++) queue_byte(8'h00, i == 4);
    // alternating extremes
    for (int i = 0; i < 6; i++) queue_byte((i % 2) ? 8'hFF : 8'h00, i == 5);
    for (int i = 0; i < 3; i++) queue_byte(byte_t'(i + 1), i == 2);

    // hold off until the directed messages have fully drained
    wait_drained();

    while (queued_bytes < RAND_BYTES) begin
      if (!long_done && queued_bytes >= 500) begin
        // long message so the position counter wraps
        len = $urandom_range(257, 300);
        long_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(25, 80);
      end else begin
        len = $urandom_range(1, 24);
      end
      queue_message(len);
      if (!paused && queued_bytes >= 850) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
